// ===== design/pair_distance_histogram_core_defines.svh =====
// ----------------------------------------------------------------------------
// pair distance histogram assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef PAIR_DISTANCE_HISTOGRAM_CORE_DEFINES_SVH
`define PAIR_DISTANCE_HISTOGRAM_CORE_DEFINES_SVH

// implication checked in the same cycle
`define PDH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdh check failed");

// implication checked in the next cycle
`define PDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdh check failed");

`endif

// ===== design/pdh_pkg.sv =====
// ----------------------------------------------------------------------------
// pdh_pkg
// shared types and constants of the pair distance histogram
// ----------------------------------------------------------------------------
package pdh_pkg;

	localparam int COORD_W = 24;
	localparam int OP_W    = 2;
	localparam int SEL_W   = 11;
	localparam int NORM_W  = 17;
	localparam int OUT_W   = 32;
	localparam int SCALE_W = 10;
	localparam logic [SCALE_W-1:0] DIST_SCALE = 10'd1000;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic   start;
		coord_t p0_x;
		coord_t p0_y;
		coord_t p0_z;
		coord_t p1_x;
		coord_t p1_y;
		coord_t p1_z;
	} dist_req_t;

	typedef struct packed {
		logic done;
		logic beyond;
	} dist_rsp_t;

	typedef enum logic [2:0] {
		DS_IDLE,
		DS_SQ,
		DS_SCALE1,
		DS_SCALE2,
		DS_ROOT
	} dist_state_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIST,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_RD_ISSUE,
		ST_RD_WAIT,
		ST_DIV,
		ST_EMIT
	} pdh_state_t;

endpackage

// ===== design/pdh_if.sv =====
// ----------------------------------------------------------------------------
// pdh_if
// request and result channels of the pair distance histogram
// ----------------------------------------------------------------------------
interface pdh_in_if;
	logic                          valid;
	logic                          ready;
	logic [pdh_pkg::OP_W-1:0]      operation;
	pdh_pkg::coord_t               first_x;
	pdh_pkg::coord_t               first_y;
	pdh_pkg::coord_t               first_z;
	pdh_pkg::coord_t               second_x;
	pdh_pkg::coord_t               second_y;
	pdh_pkg::coord_t               second_z;
	logic [pdh_pkg::SEL_W-1:0]     bin_select;

	modport source (output valid, operation, first_x, first_y, first_z,
		second_x, second_y, second_z, bin_select, input ready);
	modport sink (input valid, operation, first_x, first_y, first_z,
		second_x, second_y, second_z, bin_select, output ready);
endinterface

interface pdh_out_if;
	logic                          valid;
	logic                          ready;
	logic [pdh_pkg::NORM_W-1:0]    normalized_value;
	logic [pdh_pkg::OUT_W-1:0]     raw_count;
	logic [pdh_pkg::OUT_W-1:0]     peak_count;
	logic                          range_error;

	modport source (output valid, normalized_value, raw_count, peak_count,
		range_error, input ready);
	modport sink (input valid, normalized_value, raw_count, peak_count,
		range_error, output ready);
endinterface

// ===== design/pdh_ram.sv =====
// ----------------------------------------------------------------------------
// pdh_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module pdh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1733
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== design/pdh_dist.sv =====
// ----------------------------------------------------------------------------
// pdh_dist
// squared distance, scaling and bitwise integer root to a bin index
// ----------------------------------------------------------------------------
module pdh_dist #(
	parameter int NUM_BINS        = 1733,
	parameter int COORD_FRAC_BITS = 16,
	localparam int BW             = $clog2(NUM_BINS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pdh_pkg::dist_req_t req,
	output pdh_pkg::dist_rsp_t rsp,
	output logic [BW-1:0]      bin
);
	import pdh_pkg::*;

	localparam int DW   = COORD_W + 1;
	localparam int SW   = 2 * DW + 2;
	localparam int X1W  = SW + SCALE_W;
	localparam int XW   = X1W + SCALE_W;
	localparam int YW   = XW - 2 * COORD_FRAC_BITS;
	localparam int KW   = (BW > 1) ? $clog2(BW) : 1;
	localparam int CMPW = (YW > 2 * BW) ? YW : 2 * BW;

	dist_state_t state_q, state_d;
	logic [1:0]     phase_q;
	logic [KW-1:0]  k_q;
	logic [BW-1:0]  root_q;
	logic [SW-1:0]  acc_q;
	logic [X1W-1:0] x1_q;
	logic [XW-1:0]  x_q;
	logic           done_q;
	coord_t         p0_q [3];
	coord_t         p1_q [3];

	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;
	logic [2*DW-1:0]      sq;
	logic [BW-1:0]        cand;
	logic [2*BW-1:0]      cand_sq;
	logic                 fits;
	logic                 sq_last, root_last;

	// one axis per cycle
	assign diff    = DW'(p0_q[phase_q]) - DW'(p1_q[phase_q]);
	assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
	assign sq      = (2*DW)'(mag) * (2*DW)'(mag);
	assign cand    = root_q | (BW'(1) << k_q);
	assign cand_sq = (2*BW)'(cand) * (2*BW)'(cand);
	assign fits    = CMPW'(x_q[XW-1:2*COORD_FRAC_BITS]) >= CMPW'(cand_sq);

	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE:   if (req.start) state_d = DS_SQ;
			DS_SQ:     if (phase_q == 2'd2) state_d = DS_SCALE1;
			DS_SCALE1: state_d = DS_SCALE2;
			DS_SCALE2: state_d = DS_ROOT;
			DS_ROOT:   if (k_q == '0) state_d = DS_IDLE;
			default:   state_d = DS_IDLE;
		endcase
	end

	always_comb begin
		sq_last   = 1'b0;
		root_last = 1'b0;
		case (state_q)
			DS_SQ:   sq_last = (phase_q == 2'd2);
			DS_ROOT: root_last = (k_q == '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= root_last;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DS_IDLE: begin
				p0_q[0] <= req.p0_x;
				p0_q[1] <= req.p0_y;
				p0_q[2] <= req.p0_z;
				p1_q[0] <= req.p1_x;
				p1_q[1] <= req.p1_y;
				p1_q[2] <= req.p1_z;
				acc_q   <= '0;
				phase_q <= '0;
			end
			DS_SQ: begin
				acc_q   <= acc_q + SW'(sq);
				phase_q <= sq_last ? 2'd0 : phase_q + 2'd1;
			end
			DS_SCALE1: x1_q <= X1W'(acc_q) * X1W'(DIST_SCALE);
			DS_SCALE2: begin
				x_q    <= XW'(x1_q) * XW'(DIST_SCALE);
				root_q <= '0;
				k_q    <= KW'(BW - 1);
			end
			DS_ROOT: begin
				if (fits) root_q <= cand;
				if (!root_last) k_q <= k_q - KW'(1);
			end
			default: ;
		endcase
	end

	assign bin        = root_q;
	assign rsp.done   = done_q;
	assign rsp.beyond = root_q >= BW'(NUM_BINS);
endmodule

// ===== design/pdh_div.sv =====
// ----------------------------------------------------------------------------
// pdh_div
// restoring divider for count * 2^16 / peak, count not above peak
// ----------------------------------------------------------------------------
module pdh_div #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [COUNT_WIDTH-1:0]        numer,
	input  logic [COUNT_WIDTH-1:0]        denom,
	output logic                          done,
	output logic [pdh_pkg::NORM_W-1:0]    quot
);
	import pdh_pkg::*;

	localparam int SCW = $clog2(NORM_W);

	logic                   busy_q, done_q;
	logic [SCW-1:0]         step_q;
	logic [COUNT_WIDTH:0]   rem_q;
	logic [COUNT_WIDTH-1:0] den_q;
	logic [NORM_W-1:0]      quot_q;
	logic                   ge;
	logic [COUNT_WIDTH:0]   rem_sub;

	assign ge      = rem_q >= {1'b0, den_q};
	assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) busy_q <= 1'b1;
			else if (step_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, numer};
			den_q  <= denom;
			quot_q <= '0;
			step_q <= SCW'(NORM_W - 1);
		end else if (busy_q) begin
			// remainder stays below the divisor, so the shift cannot overflow
			rem_q  <= {rem_sub[COUNT_WIDTH-1:0], 1'b0};
			quot_q <= {quot_q[NORM_W-2:0], ge};
			if (step_q != '0) step_q <= step_q - SCW'(1);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

// ===== design/pair_distance_histogram_core.sv =====
// add pair: square each axis, scale twice, BW-bit root, then read and write the bin
// read bin: ram read, a 17-step division when count and peak are nonzero, then emit
// clear: one bin written per cycle through the single ram port
// one request in flight at a time; next request taken once the current one retires
// reset: asynchronous, starts the same clearing pass with ready low
// ----------------------------------------------------------------------------
// pair_distance_histogram_core
// histogram of scaled euclidean distances between pairs of 3d points
// ----------------------------------------------------------------------------
module pair_distance_histogram_core #(
	parameter int NUM_BINS        = 1733,
	parameter int COUNT_WIDTH     = 32,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	pdh_in_if.sink   in_ch,
	pdh_out_if.source out_ch
);
	import pdh_pkg::*;

	localparam int IW = $clog2(NUM_BINS);
	localparam int BW = $clog2(NUM_BINS + 1);

	pdh_state_t state_q, state_d;

	// histogram storage
	logic                   ram_we;
	logic [IW-1:0]          ram_addr;
	logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

	logic [IW-1:0]          clr_addr_q;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic                   ovf_q;
	logic [BW-1:0]          bin_q;
	logic [SEL_W-1:0]       sel_q;
	logic                   sel_ok_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [NORM_W-1:0]      norm_q;

	logic                   out_valid_q;
	logic [NORM_W-1:0]      out_norm_q;
	logic [OUT_W-1:0]       out_raw_q, out_peak_q;
	logic                   out_err_q;

	dist_req_t              dreq;
	dist_rsp_t              drsp;
	logic [BW-1:0]          dbin;

	logic                   div_start, div_done;
	logic [NORM_W-1:0]      div_quot;

	logic                   accept;
	logic                   clr_last;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic                   need_div;
	logic                   slot_free;

	pdh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	pdh_dist #(.NUM_BINS(NUM_BINS), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp),
		.bin    (dbin)
	);

	pdh_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (rd_cnt),
		.denom  (peak_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign accept    = in_ch.valid && in_ch.ready;
	assign clr_last  = clr_addr_q == IW'(NUM_BINS - 1);
	// saturating increment of the bin being updated
	assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
	// out-of-range reads report a zero count
	assign rd_cnt    = sel_ok_q ? ram_rdata : '0;
	assign need_div  = (peak_q != '0) && (rd_cnt != '0);
	assign slot_free = !out_valid_q || out_ch.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (in_ch.operation)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_ADD:   state_d = ST_DIST;
						OP_READ:  state_d = ST_RD_ISSUE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_DIST: begin
				if (drsp.done) state_d = drsp.beyond ? ST_IDLE : ST_UPD_RD;
			end
			ST_UPD_RD:   state_d = ST_UPD_WR;
			ST_UPD_WR:   state_d = ST_IDLE;
			ST_RD_ISSUE: state_d = ST_RD_WAIT;
			ST_RD_WAIT:  state_d = need_div ? ST_DIV : ST_EMIT;
			ST_DIV:      if (div_done) state_d = ST_EMIT;
			ST_EMIT:     if (slot_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ch.ready = 1'b0;
		dreq.start  = 1'b0;
		dreq.p0_x   = in_ch.first_x;
		dreq.p0_y   = in_ch.first_y;
		dreq.p0_z   = in_ch.first_z;
		dreq.p1_x   = in_ch.second_x;
		dreq.p1_y   = in_ch.second_y;
		dreq.p1_z   = in_ch.second_z;
		div_start   = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = clr_addr_q;
		ram_wdata   = '0;
		case (state_q)
			ST_CLEAR: ram_we = 1'b1;
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				dreq.start  = accept && (in_ch.operation == OP_ADD);
			end
			ST_UPD_RD: ram_addr = IW'(bin_q);
			ST_UPD_WR: begin
				ram_we    = 1'b1;
				ram_addr  = IW'(bin_q);
				ram_wdata = cnt_inc;
			end
			ST_RD_ISSUE: ram_addr = IW'(sel_q);
			ST_RD_WAIT:  div_start = need_div;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			peak_q      <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_addr_q <= clr_last ? '0 : clr_addr_q + IW'(1);
				ST_IDLE: begin
					if (accept && (in_ch.operation == OP_CLEAR)) begin
						peak_q <= '0;
						ovf_q  <= 1'b0;
					end
				end
				ST_DIST: if (drsp.done && drsp.beyond) ovf_q <= 1'b1;
				ST_UPD_WR: if (cnt_inc > peak_q) peak_q <= cnt_inc;
				default: ;
			endcase
			if (state_q == ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q    <= in_ch.bin_select;
			sel_ok_q <= 32'(in_ch.bin_select) < 32'(NUM_BINS);
		end
		if (state_q == ST_DIST && drsp.done) bin_q <= dbin;
		if (state_q == ST_RD_WAIT) begin
			cnt_q  <= rd_cnt;
			norm_q <= '0;
		end
		if (state_q == ST_DIV && div_done) norm_q <= div_quot;
		if (state_q == ST_EMIT && slot_free) begin
			out_norm_q <= norm_q;
			out_raw_q  <= OUT_W'(cnt_q);
			out_peak_q <= OUT_W'(peak_q);
			out_err_q  <= ovf_q;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.normalized_value = out_norm_q;
	assign out_ch.raw_count        = out_raw_q;
	assign out_ch.peak_count       = out_peak_q;
	assign out_ch.range_error      = out_err_q;
endmodule

// ===== design/pdh_checker.sv =====
// ----------------------------------------------------------------------------
// pdh_checker
// port level checks of the pair distance histogram
// ----------------------------------------------------------------------------
`include "pair_distance_histogram_core_defines.svh"

module pdh_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [pdh_pkg::OP_W-1:0]      in_operation,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [pdh_pkg::NORM_W-1:0]    normalized_value,
	input logic [pdh_pkg::OUT_W-1:0]     raw_count,
	input logic [pdh_pkg::OUT_W-1:0]     peak_count
);
	logic in_busy;

	// the unused operation code leaves the core idle and ready
	assign in_busy = in_valid && in_ready && (in_operation <= pdh_pkg::OP_READ);

	`PDH_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`PDH_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_busy, !in_ready)
	`PDH_ASSERT_NOW(a_zero_peak, clk, arst_n, out_valid && peak_count == '0, normalized_value == '0)
	`PDH_ASSERT_NOW(a_zero_count, clk, arst_n, out_valid && raw_count == '0, normalized_value == '0)
endmodule

bind pair_distance_histogram_core pdh_checker u_pdh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.in_operation     (in_ch.operation),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.normalized_value (out_ch.normalized_value),
	.raw_count        (out_ch.raw_count),
	.peak_count       (out_ch.peak_count)
);
